[rtl/core/tqpi_pkg.sv]
// Shared types, constants and arithmetic helpers of the plane interpolator.
package tqpi_pkg;

  localparam int GRID_X     = 32;
  localparam int GRID_Y     = 32;
  localparam int PLANES     = 4;
  localparam int COMPONENTS = 8;

  localparam int COL_W   = $clog2(GRID_X);
  localparam int ROW_W   = $clog2(GRID_Y);
  localparam int PLANE_W = $clog2(PLANES);
  localparam int COMP_W  = $clog2(COMPONENTS);
  localparam int ADDR_W  = COMP_W + PLANE_W + ROW_W + COL_W;
  localparam int DEPTH   = GRID_X * GRID_Y * PLANES * COMPONENTS;

  // one past the highest usable cell index along x and y
  localparam logic [4:0] LIM_X = 5'(GRID_X - 3);
  localparam logic [4:0] LIM_Y = 5'(GRID_Y - 3);
  localparam logic [31:0] Z_TOP = 32'(PLANES - 2);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_INV_X    = 3'd3;
  localparam logic [2:0] REG_INV_Y    = 3'd4;
  localparam logic [2:0] REG_INV_Z    = 3'd5;
  localparam logic [2:0] REG_CELLS_X  = 3'd6;
  localparam logic [2:0] REG_CELLS_Y  = 3'd7;

  localparam logic signed [65:0] RND30  = 66'sd536870912;
  localparam logic signed [65:0] RND31  = 66'sd1073741824;
  localparam logic signed [65:0] MAX32  = 66'sd2147483647;
  localparam logic signed [65:0] MIN32  = -66'sd2147483648;

  typedef struct packed {
    logic [2:0][31:0] origin;
    logic [2:0][31:0] inv;
    logic [4:0]       cells_x;
    logic [4:0]       cells_y;
  } cfg_t;

  typedef struct packed {
    logic              is_query;
    logic [COMP_W-1:0] comp;
    logic              flip;
    logic [2:0][32:0]  mag;
    logic [2:0]        dneg;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       sample;
  } item_t;

  // Q2.30 x Q16.16 sum back to Q16.16: round half up, saturate
  function automatic logic signed [31:0] round_sat(input logic signed [65:0] s);
    logic signed [65:0] v;
    begin
      v = (s + RND30) >>> 30;
      if (v > MAX32) begin
        round_sat = 32'sh7fffffff;
      end else if (v < MIN32) begin
        round_sat = 32'sh80000000;
      end else begin
        round_sat = v[31:0];
      end
    end
  endfunction

endpackage

[rtl/core/triquadratic_plane_interpolator.sv]
// Triquadratic interpolator over a window of sample planes. Requests enter
// a two-entry queue, so the front takes new requests while a result waits.
// A load writes one sample as the back end takes it from the queue. A query
// runs in the back end as 3 axis products, 9 weights, then 27 samples read
// one at a time through the single store read port, with z, y and x blends
// sharing one multiplier and a round/saturate stage after each blend. The
// store powers up undefined; read only samples that were loaded.
module triquadratic_plane_interpolator import tqpi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               req_type,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [2:0]         component,
  input  logic               flip_velocity,
  input  logic [4:0]         cell_x,
  input  logic [4:0]         cell_y,
  input  logic [1:0]         plane,
  input  logic signed [31:0] sample_value,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] value,
  output logic [2:0]         out_component,
  output logic               in_range,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t  cfg;
  item_t f_item, q_head;
  logic  f_push, q_full, q_valid, q_pop;

  assign full = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin  <= '0;
      cfg.inv     <= {3{32'd65536}};
      cfg.cells_x <= 5'd29;
      cfg.cells_y <= 5'd29;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X: cfg.origin[0] <= cfg_data;
        REG_ORIGIN_Y: cfg.origin[1] <= cfg_data;
        REG_ORIGIN_Z: cfg.origin[2] <= cfg_data;
        REG_INV_X:    cfg.inv[0]    <= cfg_data;
        REG_INV_Y:    cfg.inv[1]    <= cfg_data;
        REG_INV_Z:    cfg.inv[2]    <= cfg_data;
        REG_CELLS_X:  cfg.cells_x   <= cfg_data[4:0];
        REG_CELLS_Y:  cfg.cells_y   <= cfg_data[4:0];
      endcase
    end
  end

  tqpi_front u_front (
    .cfg           (cfg),
    .push          (push),
    .q_full        (q_full),
    .req_type      (req_type),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .component     (component),
    .flip_velocity (flip_velocity),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .plane         (plane),
    .sample_value  (sample_value),
    .item_push     (f_push),
    .item          (f_item)
  );

  tqpi_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (f_push),
    .wr_item  (f_item),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_item  (q_head),
    .rd_en    (q_pop)
  );

  tqpi_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_head),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .value         (value),
    .out_component (out_component),
    .in_range      (in_range)
  );

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("back end took a request from an empty queue");

  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !in_range) |-> (value == '0))
    else $error("out-of-range result carries a nonzero value");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(value) && $stable(in_range)))
    else $error("waiting result changed before it was taken");

endmodule

[rtl/core/tqpi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tqpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/tqpi_front.sv]
// Front end: classifies requests and forms axis offsets and load addresses.
module tqpi_front import tqpi_pkg::*; (
  input  cfg_t               cfg,
  input  logic               push,
  input  logic               q_full,
  input  logic               req_type,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [2:0]         component,
  input  logic               flip_velocity,
  input  logic [4:0]         cell_x,
  input  logic [4:0]         cell_y,
  input  logic [1:0]         plane,
  input  logic signed [31:0] sample_value,
  output logic               item_push,
  output item_t              item
);

  logic [2:0][31:0] pos;
  logic [2:0][32:0] d;

  assign pos = {pos_z, pos_y, pos_x};
  assign item_push = push && !q_full;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d[a] = {pos[a][31], pos[a]} - {cfg.origin[a][31], cfg.origin[a]};
    end
  end

  always_comb begin
    item.is_query = req_type;
    item.comp     = component;
    item.flip     = flip_velocity;
    for (int a = 0; a < 3; a++) begin
      item.dneg[a] = d[a][32];
      item.mag[a]  = d[a][32] ? 33'(-d[a]) : d[a];
    end
    item.addr   = {component, plane, cell_y, cell_x};
    item.sample = sample_value;
  end

endmodule

[rtl/core/tqpi_queue.sv]
// Two-entry request queue between front end and back end.
module tqpi_queue import tqpi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wr_item,
  output logic  full,
  output logic  rd_valid,
  output item_t rd_item,
  input  logic  rd_en
);

  item_t             slot [QDEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slot[rp];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wp] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wp <= wp + 1'b1;
      end
      if (rd_en) begin
        rp <= rp + 1'b1;
      end
      count <= count + (QPTR_W+1)'(wr_en) - (QPTR_W+1)'(rd_en);
    end
  end

endmodule

[rtl/core/tqpi_back.sv]
// Back end: sample store, shared multiplier and the interpolation sequencer.
module tqpi_back import tqpi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] value,
  output logic [2:0]         out_component,
  output logic               in_range
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_AX   = 4'd1;
  localparam logic [3:0] S_WT   = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_ZM   = 4'd5;
  localparam logic [3:0] S_ZW   = 4'd6;
  localparam logic [3:0] S_YM   = 4'd7;
  localparam logic [3:0] S_YW   = 4'd8;
  localparam logic [3:0] S_XM   = 4'd9;
  localparam logic [3:0] S_XW   = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  localparam logic [2:0] TAG_NONE = 3'd0;
  localparam logic [2:0] TAG_AX   = 3'd1;
  localparam logic [2:0] TAG_WT   = 3'd2;
  localparam logic [2:0] TAG_Z    = 3'd3;
  localparam logic [2:0] TAG_Y    = 3'd4;
  localparam logic [2:0] TAG_X    = 3'd5;

  localparam logic signed [33:0] ONE30 = 34'sd1073741824;
  localparam logic signed [33:0] TWO30 = 34'sd2147483648;

  logic [3:0] state;
  logic [1:0] cnt_a, cnt_k, cnt_i, cnt_j;

  // latched query
  logic [2:0][32:0]  mag;
  logic [2:0]        dneg;
  logic [COMP_W-1:0] comp;
  logic              flip;
  logic              ok;

  // per-axis results
  logic [31:0]        r_r   [3];
  logic signed [31:0] t_r   [3];
  logic [2:0]         neg_r;
  logic [2:0]         big_r;
  logic signed [31:0] w_r   [9];

  logic signed [65:0] accz, accy, accx;
  logic signed [31:0] zd, yd, fin;

  // multiplier
  logic signed [33:0] mul_a, mul_b;
  logic [2:0]         mul_tag;
  logic [3:0]         mul_idx;
  logic               mul_last, mul_half;
  logic signed [67:0] mul_full;
  logic signed [65:0] pr;
  logic [2:0]         pr_tag;
  logic [3:0]         pr_idx;
  logic               pr_last, pr_half;

  // store ports
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;
  logic [1:0]        rd_i, rd_j, rd_k;

  logic [3:0]         widx;
  logic signed [31:0] wsel;
  logic signed [31:0] tcur;
  logic [4:0]         lim_x, lim_y;
  logic               ok_now;
  logic signed [65:0] acc_sum;
  logic signed [31:0] blend_val;
  logic signed [31:0] res_val;

  logic [63:0]        prod;
  logic [64:0]        prod_rnd;
  logic signed [32:0] f33, t33;

  logic               out_valid;

  assign q_pop  = (state == S_IDLE) && q_valid;
  assign ram_we = q_pop && !q_item.is_query;
  assign empty  = !out_valid;

  tqpi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_item.addr),
    .wdata (q_item.sample),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // neighborhood read address
  always_comb begin
    ram_re = 1'b0;
    rd_i   = cnt_i;
    rd_j   = cnt_j;
    rd_k   = 2'd0;
    unique case (state)
      S_RD: ram_re = 1'b1;
      S_ZM: begin
        ram_re = (cnt_k != 2'd2);
        rd_k   = cnt_k + 2'd1;
      end
      S_YM: begin
        ram_re = (cnt_j != 2'd2);
        rd_j   = cnt_j + 2'd1;
      end
      S_XM: begin
        ram_re = (cnt_i != 2'd2);
        rd_i   = cnt_i + 2'd1;
        rd_j   = 2'd0;
      end
      default: ram_re = 1'b0;
    endcase
    ram_raddr = {comp,
                 PLANE_W'(r_r[2][PLANE_W-1:0] - PLANE_W'(1) + PLANE_W'(rd_k)),
                 ROW_W'(r_r[1][ROW_W-1:0] + ROW_W'(1) + ROW_W'(rd_j)),
                 COL_W'(r_r[0][COL_W-1:0] + COL_W'(1) + COL_W'(rd_i))};
  end

  // weight table index: x weights 0..2, y 3..5, z 6..8
  always_comb begin
    unique case (state)
      S_ZM:    widx = 4'd6 + {2'b0, cnt_k};
      S_YM:    widx = 4'd3 + {2'b0, cnt_j};
      default: widx = {2'b0, cnt_i};
    endcase
  end
  assign wsel = w_r[widx];
  assign tcur = t_r[cnt_a];

  // multiplier operand selection
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_tag  = TAG_NONE;
    mul_idx  = '0;
    mul_last = 1'b0;
    mul_half = 1'b0;
    unique case (state)
      S_AX: begin
        mul_a   = $signed({1'b0, mag[cnt_a]});
        mul_b   = $signed({2'b0, cfg.inv[cnt_a]});
        mul_tag = TAG_AX;
        mul_idx = {2'b0, cnt_a};
      end
      S_WT: begin
        mul_tag  = TAG_WT;
        mul_idx  = {2'b0, cnt_a} + {2'b0, cnt_a} + {2'b0, cnt_a} + {2'b0, cnt_k};
        mul_half = (cnt_k != 2'd1);
        case (cnt_k)
          2'd0: begin
            mul_a = 34'(tcur) - ONE30;
            mul_b = 34'(tcur) - TWO30;
          end
          2'd1: begin
            mul_a = 34'(tcur);
            mul_b = TWO30 - 34'(tcur);
          end
          default: begin
            mul_a = 34'(tcur);
            mul_b = 34'(tcur) - ONE30;
          end
        endcase
      end
      S_ZM: begin
        mul_a    = 34'(wsel);
        mul_b    = 34'($signed(ram_rdata));
        mul_tag  = TAG_Z;
        mul_last = (cnt_k == 2'd2);
      end
      S_YM: begin
        mul_a    = 34'(wsel);
        mul_b    = 34'(zd);
        mul_tag  = TAG_Y;
        mul_last = (cnt_j == 2'd2);
      end
      S_XM: begin
        mul_a    = 34'(wsel);
        mul_b    = 34'(yd);
        mul_tag  = TAG_X;
        mul_last = (cnt_i == 2'd2);
      end
      default: mul_tag = TAG_NONE;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    pr      <= mul_full[65:0];
    pr_idx  <= mul_idx;
    pr_last <= mul_last;
    pr_half <= mul_half;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_tag <= TAG_NONE;
    end else begin
      pr_tag <= mul_tag;
    end
  end

  // axis split of the product: r = round(u), t = u - r in Q2.30
  assign prod     = pr[63:0];
  assign prod_rnd = {1'b0, prod} + 65'h80000000;
  assign f33      = 33'($signed(prod[31:0]));
  assign t33      = dneg[pr_idx[1:0]] ? -f33 : f33;

  always_comb begin
    case (pr_tag)
      TAG_Z:   acc_sum = accz + pr;
      TAG_Y:   acc_sum = accy + pr;
      default: acc_sum = accx + pr;
    endcase
  end
  assign blend_val = round_sat(acc_sum);

  always_ff @(posedge clk) begin
    case (pr_tag)
      TAG_AX: begin
        r_r[pr_idx[1:0]]   <= prod_rnd[63:32];
        t_r[pr_idx[1:0]]   <= {t33[32], t33[32:2]};
        neg_r[pr_idx[1:0]] <= dneg[pr_idx[1:0]] && (prod != '0);
        big_r[pr_idx[1:0]] <= (prod[63:31] != '0);
      end
      TAG_WT: begin
        if (pr_half) begin
          w_r[pr_idx] <= 32'((pr + RND31) >>> 31);
        end else begin
          w_r[pr_idx] <= 32'((pr + RND30) >>> 30);
        end
      end
      TAG_Z: begin
        accz <= pr_last ? '0 : acc_sum;
        if (pr_last) zd <= blend_val;
      end
      TAG_Y: begin
        accy <= pr_last ? '0 : acc_sum;
        if (pr_last) yd <= blend_val;
      end
      TAG_X: begin
        accx <= pr_last ? '0 : acc_sum;
        if (pr_last) fin <= blend_val;
      end
      default: begin
        if (state == S_IDLE) begin
          accz <= '0;
          accy <= '0;
          accx <= '0;
        end
      end
    endcase
  end

  assign lim_x = (cfg.cells_x < LIM_X) ? cfg.cells_x : LIM_X;
  assign lim_y = (cfg.cells_y < LIM_Y) ? cfg.cells_y : LIM_Y;
  assign ok_now = !(neg_r[0] && r_r[0] != '0) && !(neg_r[1] && r_r[1] != '0)
               && (r_r[0] < {27'b0, lim_x}) && (r_r[1] < {27'b0, lim_y})
               && !neg_r[2] && big_r[2] && (r_r[2] <= Z_TOP);

  // velocity components flip sign on the high-side face
  always_comb begin
    if (!ok) begin
      res_val = '0;
    end else if (flip && comp < COMP_W'(3)) begin
      res_val = (fin == 32'sh80000000) ? 32'sh7fffffff : -fin;
    end else begin
      res_val = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.is_query) begin
      mag  <= q_item.mag;
      dneg <= q_item.dneg;
      comp <= q_item.comp;
      flip <= q_item.flip;
    end
    if (state == S_CHK) begin
      ok <= ok_now;
    end
    if (state == S_DONE && (!out_valid || pop)) begin
      value         <= res_val;
      out_component <= 3'(comp);
      in_range      <= ok;
    end
  end

  // result register: loaded from DONE, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || pop)) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt_a     <= '0;
      cnt_k     <= '0;
      cnt_i     <= '0;
      cnt_j     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          cnt_a <= '0;
          cnt_k <= '0;
          if (q_valid && q_item.is_query) begin
            state <= S_AX;
          end
        end
        S_AX: begin
          cnt_a <= (cnt_a == 2'd2) ? 2'd0 : cnt_a + 2'd1;
          if (cnt_a == 2'd2) state <= S_WT;
        end
        S_WT: begin
          if (cnt_k == 2'd2) begin
            cnt_k <= '0;
            cnt_a <= cnt_a + 2'd1;
            if (cnt_a == 2'd2) state <= S_CHK;
          end else begin
            cnt_k <= cnt_k + 2'd1;
          end
        end
        S_CHK: begin
          cnt_i <= '0;
          cnt_j <= '0;
          cnt_k <= '0;
          state <= ok_now ? S_RD : S_DONE;
        end
        S_RD: state <= S_ZM;
        S_ZM: begin
          if (cnt_k == 2'd2) begin
            state <= S_ZW;
          end else begin
            cnt_k <= cnt_k + 2'd1;
          end
        end
        S_ZW: state <= S_YM;
        S_YM: begin
          cnt_k <= '0;
          if (cnt_j == 2'd2) begin
            state <= S_YW;
          end else begin
            cnt_j <= cnt_j + 2'd1;
            state <= S_ZM;
          end
        end
        S_YW: state <= S_XM;
        S_XM: begin
          cnt_k <= '0;
          cnt_j <= '0;
          if (cnt_i == 2'd2) begin
            state <= S_XW;
          end else begin
            cnt_i <= cnt_i + 2'd1;
            state <= S_ZM;
          end
        end
        S_XW: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || pop) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
